/* rtl/core/rlc_pkg.sv */
`timescale 1ns / 1ps

package rlc_pkg;

  localparam int unsigned LIGHT_COUNT_DEF = 6;
  localparam int unsigned PALETTE_SIZE    = 12;
  localparam int unsigned PAL_TABLE_LEN   = 12;

  localparam int unsigned TIME_W  = 24;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CFG_W   = 24;

  localparam logic [7:0] FULL = 8'hFF;
  localparam logic [7:0] HALF = 8'h80;

  localparam logic [COLOR_W-1:0] STAGE_INIT_HI = {FULL, FULL, 8'h00};
  localparam logic [COLOR_W-1:0] STAGE_INIT_LO = {HALF, FULL, 8'h00};

  localparam logic [TIME_W-1:0] SPEED_RESET = 24'h010000;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ENTER = 2'd1,
    ACT_LEAVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_SPEED = 2'd0,
    CFG_HOLD  = 2'd1,
    CFG_GROUP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    action_e           action;
    logic              is_player;
    logic [TIME_W-1:0] delta_time;
  } item_t;

  function automatic logic [COLOR_W-1:0] palette_color(input logic [3:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      4'd0:    c = {8'h00, FULL, 8'h00};
      4'd1:    c = {8'h00, FULL, HALF};
      4'd2:    c = {8'h00, FULL, FULL};
      4'd3:    c = {8'h00, HALF, FULL};
      4'd4:    c = {8'h00, 8'h00, FULL};
      4'd5:    c = {HALF, 8'h00, FULL};
      4'd6:    c = {FULL, 8'h00, FULL};
      4'd7:    c = {FULL, 8'h00, HALF};
      4'd8:    c = {FULL, 8'h00, 8'h00};
      4'd9:    c = {FULL, HALF, 8'h00};
      4'd10:   c = {FULL, FULL, 8'h00};
      4'd11:   c = {HALF, FULL, 8'h00};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/rainbow_led_chase.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: delta_time; tuser: action, is_player
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: group, index, r, g, b; tlast: last light
// cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// One input word is taken per cycle; a word that fires the chase is taken
// once the output side has room for a new step, and yields LIGHT_COUNT words,
// one per cycle while m_axis_tready is high, from the output serializer.
// Asynchronous active-low reset restores the stage colors, latch,
// accumulator, palette index and hold counter. A stall on m_axis holds the
// serializer; non-firing words keep flowing meanwhile.

module rainbow_led_chase import rlc_pkg::*; #(
  parameter int unsigned LIGHT_COUNT = LIGHT_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,  // [23:0] delta_time
  input  logic [2:0]       s_axis_tuser,  // [1:0] action, [2] is_player
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [7:0] light_group, [10:8] light_index,
                                          // [18:11] red, [26:19] green, [34:27] blue
  output logic             m_axis_tlast,  // last_light
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  item_t                               in_item;
  logic                                emit_ready;
  logic                                fire;
  logic [7:0]                          group;
  logic [LIGHT_COUNT-1:0][COLOR_W-1:0] snap;
  logic [7:0]                          out_group;
  logic [2:0]                          out_index;
  logic [COLOR_W-1:0]                  out_color;

  always_comb begin
    in_item.action     = action_e'(s_axis_tuser[1:0]);
    in_item.is_player  = s_axis_tuser[2];
    in_item.delta_time = s_axis_tdata[TIME_W-1:0];
  end

  rlc_step #(
    .LIGHT_COUNT(LIGHT_COUNT)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_item_i   (in_item),
    .in_ready_o  (s_axis_tready),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .emit_ready_i(emit_ready),
    .fire_o      (fire),
    .group_o     (group),
    .snap_o      (snap)
  );

  rlc_emit #(
    .LIGHT_COUNT(LIGHT_COUNT)
  ) u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .group_i(group),
    .snap_i (snap),
    .ready_o(emit_ready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .group_o(out_group),
    .index_o(out_index),
    .color_o(out_color),
    .last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_color[7:0], out_color[15:8], out_color[23:16],
                         out_index, out_group};

endmodule

/* rtl/core/rlc_step.sv */
`timescale 1ns / 1ps

module rlc_step import rlc_pkg::*; #(
  parameter int unsigned LIGHT_COUNT = LIGHT_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  item_t                               in_item_i,
  output logic                                in_ready_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [CFG_W-1:0]                    cfg_data_i,
  input  logic                                emit_ready_i,
  output logic                                fire_o,
  output logic [7:0]                          group_o,
  output logic [LIGHT_COUNT-1:0][COLOR_W-1:0] snap_o
);

  logic                                vld_q;
  item_t                               item_q;
  logic [TIME_W-1:0]                   thr_q;
  logic [7:0]                          hold_cfg_q;
  logic [7:0]                          group_q;
  logic                                latch_q;
  logic [TIME_W-1:0]                   acc_q;
  logic [3:0]                          pal_q;
  logic [7:0]                          hold_q;
  logic [LIGHT_COUNT-1:0][COLOR_W-1:0] stage_q;

  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] acc_sat;
  logic              fire;
  logic              consume;
  logic [4:0]        pal_inc;
  logic [3:0]        pal_d;

  always_comb begin
    sum     = {1'b0, acc_q} + {1'b0, item_q.delta_time};
    acc_sat = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    fire    = vld_q && (item_q.action == ACT_TICK) && latch_q && (acc_sat > thr_q);
    consume = vld_q && (!fire || emit_ready_i);
    pal_inc = {1'b0, pal_q} + 5'd1;
    pal_d   = (pal_inc >= 5'(PALETTE_SIZE)) ? '0 : pal_inc[3:0];
  end

  assign in_ready_o = !vld_q || consume;
  assign fire_o     = fire && emit_ready_i;
  assign group_o    = group_q;
  assign snap_o     = stage_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      thr_q      <= SPEED_RESET;
      hold_cfg_q <= '0;
      group_q    <= '0;
      latch_q    <= 1'b0;
      acc_q      <= '0;
      pal_q      <= '0;
      hold_q     <= '0;
      for (int i = 0; i < LIGHT_COUNT; i++) begin
        stage_q[i] <= (i < 2) ? STAGE_INIT_HI : STAGE_INIT_LO;
      end
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SPEED: thr_q      <= cfg_data_i[TIME_W-1:0];
          CFG_HOLD:  hold_cfg_q <= cfg_data_i[7:0];
          CFG_GROUP: group_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (consume) begin
        case (item_q.action)
          ACT_TICK: begin
            if (latch_q) begin
              acc_q <= fire ? '0 : acc_sat;
            end
          end
          ACT_ENTER, ACT_LEAVE: begin
            if (item_q.is_player) begin
              latch_q <= (item_q.action == ACT_ENTER);
            end
          end
          default: ;
        endcase
      end

      if (consume && fire) begin
        for (int i = 0; i < LIGHT_COUNT - 1; i++) begin
          stage_q[i] <= stage_q[i+1];
        end
        if ({1'b0, pal_q} < 5'(PAL_TABLE_LEN)) begin
          stage_q[LIGHT_COUNT-1] <= palette_color(pal_q);
        end
        if (hold_q == hold_cfg_q) begin
          hold_q <= '0;
          pal_q  <= pal_d;
        end else begin
          hold_q <= hold_q + 8'd1;
        end
      end
    end
  end

`ifndef SYNTH
  a_fire_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && fire) |=> (acc_q == '0))
    else $error("accumulator not cleared after firing");

  a_pal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pal_q} < 5'(PALETTE_SIZE)))
    else $error("palette index out of range");
`endif

endmodule

/* rtl/core/rlc_emit.sv */
`timescale 1ns / 1ps

module rlc_emit import rlc_pkg::*; #(
  parameter int unsigned LIGHT_COUNT = LIGHT_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [7:0]                          group_i,
  input  logic [LIGHT_COUNT-1:0][COLOR_W-1:0] snap_i,
  output logic                                ready_o,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [7:0]                          group_o,
  output logic [2:0]                          index_o,
  output logic [COLOR_W-1:0]                  color_o,
  output logic                                last_o
);

  localparam int unsigned IW = $clog2(LIGHT_COUNT + 1);

  logic                                busy_q;
  logic                                last_q;
  logic [IW-1:0]                       idx_q;
  logic [7:0]                          group_q;
  logic [LIGHT_COUNT-1:0][COLOR_W-1:0] colors_q;
  logic [7:0]                          idx_ext;

  assign ready_o = !busy_q || (ready_i && last_q);
  assign valid_o = busy_q;
  assign group_o = group_q;
  assign color_o = colors_q[0];
  assign last_o  = last_q;
  assign idx_ext = 8'(idx_q);
  assign index_o = idx_ext[2:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      colors_q <= snap_i;
      group_q  <= group_i;
    end else if (busy_q && ready_i) begin
      for (int i = 0; i < LIGHT_COUNT - 1; i++) begin
        colors_q[i] <= colors_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      last_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      last_q <= 1'b0;
      idx_q  <= IW'(1);
    end else if (busy_q && ready_i) begin
      if (last_q) begin
        busy_q <= 1'b0;
        last_q <= 1'b0;
      end else begin
        idx_q  <= idx_q + IW'(1);
        last_q <= (idx_q == IW'(LIGHT_COUNT - 1));
      end
    end
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || (ready_i && last_q)))
    else $error("snapshot loaded over pending words");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && last_q) |-> (idx_q == IW'(LIGHT_COUNT)))
    else $error("last word at wrong light number");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !last_q && ready_i && !load_i) |=>
      (busy_q && (idx_q == $past(idx_q) + IW'(1))))
    else $error("light number did not advance");
`endif

endmodule
